/* design/nug_pkg.sv */
package nug_pkg;

    localparam int unsigned XW          = 32;
    localparam int unsigned DW          = 33;
    localparam int unsigned WW          = 128;
    localparam int unsigned IDXW        = 16;
    localparam int unsigned STW         = 2;
    localparam int unsigned MAX_POINTS_DEF = 65536;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    localparam logic [STW-1:0] ST_OK    = 2'd0;
    localparam logic [STW-1:0] ST_SAT   = 2'd1;
    localparam logic [STW-1:0] ST_SHORT = 2'd2;

    localparam logic [XW-1:0] SLOPE_POS = 32'h7FFF_FFFF;
    localparam logic [XW-1:0] SLOPE_NEG = 32'h8000_0000;

    // which point of the three-sample window a job computes
    typedef enum logic [1:0] {
        KIND_FWD = 2'd0,
        KIND_CTR = 2'd1,
        KIND_BWD = 2'd2
    } kind_t;

    function automatic logic [WW-1:0] sext_d(input logic [DW-1:0] d);
        return {{(WW - DW){d[DW-1]}}, d};
    endfunction

    function automatic logic [WW-1:0] abs_w(input logic [WW-1:0] v);
        return v[WW-1] ? (WW'(0) - v) : v;
    endfunction

endpackage

/* design/nonuniform_grid_gradient_top.sv */
// Channel   Direction  Ports                                         Transfer
// s_ (in)   sink       s_x_value s_y_value s_last_sample             s_valid & s_ready
// m_ (out)  source     m_slope m_point_index m_status m_final_result m_valid & m_ready
//
// A slope result with a nonzero divisor runs six bit-serial 128-bit multiplies,
// each after a start step, one setup step, a 128-bit restoring divider (one
// quotient bit a cycle), one rounding step and one output step.
// An item gives zero to three results.
// Reset (aresetn low, synchronous) clears windows, count, state and m_valid.
// A stalled m_ready keeps the older result in the output register and the new
// one waiting in S_EMIT; the next input is taken once an item's last job is emitted.
module nonuniform_grid_gradient_top #(
    parameter int unsigned MAX_POINTS = nug_pkg::MAX_POINTS_DEF,
    parameter int unsigned FRAC_BITS  = nug_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [nug_pkg::XW-1:0] s_x_value,
    input  logic signed [nug_pkg::XW-1:0] s_y_value,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [nug_pkg::XW-1:0] m_slope,
    output logic [nug_pkg::IDXW-1:0]      m_point_index,
    output logic [nug_pkg::STW-1:0]       m_status,
    output logic                          m_final_result
);
    import nug_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

    // multiply sequence steps
    localparam logic [2:0] OP_D2SQ = 3'd0;  // d2*d2
    localparam logic [2:0] OP_NUMA = 3'd1;  // *e1 -> num
    localparam logic [2:0] OP_D1SQ = 3'd2;  // d1*d1
    localparam logic [2:0] OP_NUMB = 3'd3;  // *e2 -> num -=
    localparam logic [2:0] OP_D1D2 = 3'd4;  // d1*d2
    localparam logic [2:0] OP_DEN  = 3'd5;  // *d21 -> den

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

    state_t state_reg;

    // sample window, oldest first
    logic [XW-1:0]    xw_reg [3];
    logic [XW-1:0]    yw_reg [3];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] n_reg;

    // pending jobs of the current item
    logic             job_ctr_reg, job_bwd_reg;
    kind_t            kind_reg;

    // shift-add multiplier
    logic [WW-1:0]    acc_reg, a_reg, p_reg, num_reg, den_reg;
    logic [DW-1:0]    b_reg;
    logic [5:0]       step_reg;
    logic [2:0]       op_reg;

    // restoring divider
    logic [WW-1:0]    rem_reg, quo_reg, dn_reg;
    logic             neg_reg;
    logic [6:0]       bit_reg;

    // result waiting for the output register
    logic [XW-1:0]    res_slope_reg;
    logic [IDXW-1:0]  res_index_reg;
    logic [STW-1:0]   res_status_reg;
    logic             res_final_reg;

    logic             m_valid_reg;
    logic [XW-1:0]    m_slope_reg;
    logic [IDXW-1:0]  m_index_reg;
    logic [STW-1:0]   m_status_reg;
    logic             m_final_reg;

    // point r and the two others u, v, chosen by job kind
    logic [XW-1:0]    xr, yr, xu, yu, xv, yv;
    logic [DW-1:0]    d1, d2, d21, e1, e2;
    logic [WW-1:0]    a_sel;
    logic [DW-1:0]    b_sel;
    logic [WW-1:0]    acc_next;
    logic [WW-1:0]    trial;
    logic             ge;
    logic             rnd;
    logic [WW-1:0]    q_rnd;
    logic             s_fire;
    logic [CNT_W-1:0] n_new;
    logic             last_eff;
    logic             out_free;
    logic [31:0]      idx_wide;
    kind_t            next_kind;
    logic             more_jobs;

    always_comb begin
        xr = xw_reg[0]; yr = yw_reg[0];
        xu = xw_reg[1]; yu = yw_reg[1];
        xv = xw_reg[2]; yv = yw_reg[2];
        unique case (kind_reg)
            KIND_FWD: begin
                xr = xw_reg[0]; yr = yw_reg[0];
                xu = xw_reg[1]; yu = yw_reg[1];
                xv = xw_reg[2]; yv = yw_reg[2];
            end
            KIND_CTR: begin
                xr = xw_reg[1]; yr = yw_reg[1];
                xu = xw_reg[0]; yu = yw_reg[0];
                xv = xw_reg[2]; yv = yw_reg[2];
            end
            KIND_BWD: begin
                xr = xw_reg[2]; yr = yw_reg[2];
                xu = xw_reg[1]; yu = yw_reg[1];
                xv = xw_reg[0]; yv = yw_reg[0];
            end
            default: ;
        endcase
    end

    assign d1  = {xu[XW-1], xu} - {xr[XW-1], xr};
    assign d2  = {xv[XW-1], xv} - {xr[XW-1], xr};
    assign d21 = {xv[XW-1], xv} - {xu[XW-1], xu};
    assign e1  = {yu[XW-1], yu} - {yr[XW-1], yr};
    assign e2  = {yv[XW-1], yv} - {yr[XW-1], yr};

    // op sequence: d2*d2, *e1 -> num; d1*d1, *e2 -> num -= ; d1*d2, *d21 -> den
    always_comb begin
        a_sel = sext_d(d2);
        b_sel = d2;
        case (op_reg)
            OP_D2SQ: begin a_sel = sext_d(d2); b_sel = d2;  end
            OP_NUMA: begin a_sel = p_reg;      b_sel = e1;  end
            OP_D1SQ: begin a_sel = sext_d(d1); b_sel = d1;  end
            OP_NUMB: begin a_sel = p_reg;      b_sel = e2;  end
            OP_D1D2: begin a_sel = sext_d(d1); b_sel = d2;  end
            default: begin a_sel = p_reg;      b_sel = d21; end
        endcase
    end

    // multiplier bit DW-1 carries negative weight
    always_comb begin
        acc_next = acc_reg;
        if (b_reg[0]) begin
            acc_next = (step_reg == 6'(DW - 1)) ? (acc_reg - a_reg) : (acc_reg + a_reg);
        end
    end

    assign trial = {rem_reg[WW-2:0], quo_reg[WW-1]};
    assign ge    = (trial >= dn_reg);
    assign rnd   = ({rem_reg, 1'b0} >= {1'b0, dn_reg});
    assign q_rnd = quo_reg + WW'(rnd);

    assign s_fire   = s_valid && s_ready;
    assign n_new    = cnt_reg + CNT_W'(1);
    assign last_eff = s_last_sample || (32'(n_new) >= 32'(MAX_POINTS));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (kind_reg)
            KIND_FWD: idx_wide = 32'd0;
            KIND_CTR: idx_wide = 32'(n_reg) - 32'd2;
            default:  idx_wide = 32'(n_reg) - 32'd1;
        endcase
    end

    // next job after the current one is emitted
    always_comb begin
        next_kind = KIND_BWD;
        more_jobs = 1'b0;
        unique case (kind_reg)
            KIND_FWD: begin
                more_jobs = job_ctr_reg || job_bwd_reg;
                next_kind = job_ctr_reg ? KIND_CTR : KIND_BWD;
            end
            KIND_CTR: begin
                more_jobs = job_bwd_reg;
                next_kind = KIND_BWD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            job_ctr_reg <= 1'b0;
            job_bwd_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                xw_reg[i] <= '0;
                yw_reg[i] <= '0;
            end
        end else begin
            // S_EMIT drives m_valid_reg itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        n_reg <= n_new;
                        if (n_new < CNT_W'(3) && last_eff) begin
                            // short series: one error result, start over
                            cnt_reg        <= '0;
                            for (int i = 0; i < 3; i++) begin
                                xw_reg[i] <= '0;
                                yw_reg[i] <= '0;
                            end
                            res_slope_reg  <= '0;
                            res_index_reg  <= '0;
                            res_status_reg <= ST_SHORT;
                            res_final_reg  <= 1'b1;
                            job_ctr_reg    <= 1'b0;
                            job_bwd_reg    <= 1'b0;
                            kind_reg       <= KIND_BWD;
                            state_reg      <= S_EMIT;
                        end else begin
                            xw_reg[0] <= xw_reg[1];
                            xw_reg[1] <= xw_reg[2];
                            xw_reg[2] <= s_x_value;
                            yw_reg[0] <= yw_reg[1];
                            yw_reg[1] <= yw_reg[2];
                            yw_reg[2] <= s_y_value;
                            if (n_new < CNT_W'(3)) begin
                                cnt_reg <= n_new;
                            end else begin
                                cnt_reg     <= last_eff ? '0 : n_new;
                                job_ctr_reg <= 1'b1;
                                job_bwd_reg <= last_eff;
                                kind_reg    <= (n_new == CNT_W'(3)) ? KIND_FWD : KIND_CTR;
                                op_reg      <= OP_D2SQ;
                                state_reg   <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    a_reg         <= a_sel;
                    b_reg         <= b_sel;
                    acc_reg       <= '0;
                    step_reg      <= '0;
                    res_index_reg <= idx_wide[IDXW-1:0];
                    res_final_reg <= (kind_reg == KIND_BWD);
                    state_reg     <= S_MUL;
                end
                S_MUL: begin
                    acc_reg  <= acc_next;
                    a_reg    <= {a_reg[WW-2:0], 1'b0};
                    b_reg    <= {1'b0, b_reg[DW-1:1]};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(DW - 1)) begin
                        case (op_reg)
                            OP_D2SQ, OP_D1SQ, OP_D1D2: p_reg <= acc_next;
                            OP_NUMA:                   num_reg <= acc_next;
                            OP_NUMB:                   num_reg <= num_reg - acc_next;
                            default:                   den_reg <= acc_next;
                        endcase
                        op_reg    <= op_reg + 3'd1;
                        state_reg <= (op_reg == OP_DEN) ? S_PREP : S_START;
                    end
                end
                S_PREP: begin
                    if (den_reg == '0) begin
                        res_status_reg <= ST_SAT;
                        if (num_reg == '0) begin
                            res_slope_reg <= '0;
                        end else begin
                            res_slope_reg <= num_reg[WW-1] ? SLOPE_NEG : SLOPE_POS;
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        neg_reg   <= num_reg[WW-1] ^ den_reg[WW-1];
                        quo_reg   <= abs_w(num_reg) << FRAC_BITS;
                        dn_reg    <= abs_w(den_reg);
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= ge ? (trial - dn_reg) : trial;
                    quo_reg <= {quo_reg[WW-2:0], ge};
                    bit_reg <= bit_reg + 7'd1;
                    if (bit_reg == 7'(WW - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    // round half away from zero, then saturate to 32 bits
                    if (|q_rnd[WW-1:XW]) begin
                        res_status_reg <= ST_SAT;
                        res_slope_reg  <= neg_reg ? SLOPE_NEG : SLOPE_POS;
                    end else if (neg_reg) begin
                        if (q_rnd[XW-1:0] > SLOPE_NEG) begin
                            res_status_reg <= ST_SAT;
                            res_slope_reg  <= SLOPE_NEG;
                        end else begin
                            res_status_reg <= ST_OK;
                            res_slope_reg  <= XW'(0) - q_rnd[XW-1:0];
                        end
                    end else begin
                        if (q_rnd[XW-1]) begin
                            res_status_reg <= ST_SAT;
                            res_slope_reg  <= SLOPE_POS;
                        end else begin
                            res_status_reg <= ST_OK;
                            res_slope_reg  <= q_rnd[XW-1:0];
                        end
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_slope_reg  <= res_slope_reg;
                        m_index_reg  <= res_index_reg;
                        m_status_reg <= res_status_reg;
                        m_final_reg  <= res_final_reg;
                        if (res_final_reg) begin
                            for (int i = 0; i < 3; i++) begin
                                xw_reg[i] <= '0;
                                yw_reg[i] <= '0;
                            end
                        end
                        if (more_jobs) begin
                            kind_reg  <= next_kind;
                            op_reg    <= OP_D2SQ;
                            state_reg <= S_START;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_slope        = m_slope_reg;
    assign m_point_index  = m_index_reg;
    assign m_status       = m_status_reg;
    assign m_final_result = m_final_reg;

endmodule

/* verif/tb_nonuniform_grid_gradient_top.sv */
`timescale 1ns / 1ps

module tb_nonuniform_grid_gradient_top;
    import nug_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    // The limit covers one result's multiplies and divide, plus sink stall and source gap.
    localparam int unsigned HANG_LIMIT = 5000;
    // Drain time after the last expected result
    localparam int unsigned DRAIN_CYCLES = 1200;
    localparam int unsigned N_RANDOM = 205;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [XW-1:0] s_x_value = '0;
    logic signed [XW-1:0] s_y_value = '0;
    logic                 s_last_sample = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [XW-1:0] m_slope;
    logic [IDXW-1:0]      m_point_index;
    logic [STW-1:0]       m_status;
    logic                 m_final_result;

    always #5 aclk = ~aclk;

    nonuniform_grid_gradient_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_x_value      (s_x_value),
        .s_y_value      (s_y_value),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slope        (m_slope),
        .m_point_index  (m_point_index),
        .m_status       (m_status),
        .m_final_result (m_final_result)
    );

    // One derivative result as seen on the m_ channel
    typedef struct packed {
        logic [XW-1:0]   slope;
        logic [IDXW-1:0] idx;
        logic [STW-1:0]  st;
        logic            fin;
    } slope_res_t;

    // Directed row: sample plus an optional hand-typed expectation
    typedef struct {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic          last;
        logic          typed;   // expectation below replaces the predictor's
        slope_res_t    res;
    } sample_row_t;

    slope_res_t      pending_slopes[$];
    logic signed [XW-1:0] win_x[3];
    logic signed [XW-1:0] win_y[3];
    int unsigned     n_held;
    int unsigned     mismatches = 0;
    int unsigned     idle_cycles = 0;

    // Exact second-order three-point derivative at point r from u and v
    function automatic void point_slope(
        input  logic signed [XW-1:0] xr, yr, xu, yu, xv, yv,
        output logic [XW-1:0] sl, output logic [STW-1:0] st
    );
        logic signed [WW-1:0] d1, d2, d21, num, den;
        logic [WW-1:0]        mag, dmag, q, r;
        logic                 neg;
        d1  = WW'(xu) - WW'(xr);
        d2  = WW'(xv) - WW'(xr);
        d21 = WW'(xv) - WW'(xu);
        num = d2 * d2 * (WW'(yu) - WW'(yr)) - d1 * d1 * (WW'(yv) - WW'(yr));
        den = d1 * d2 * d21;
        st = ST_OK;
        if (den == 0) begin
            st = ST_SAT;
            sl = (num == 0) ? '0 : (num < 0) ? SLOPE_NEG : SLOPE_POS;
            return;
        end
        neg  = (num < 0) != (den < 0);
        mag  = (num < 0) ? -num : num;
        mag  = mag << FRAC_BITS_DEF;
        dmag = (den < 0) ? -den : den;
        q = mag / dmag;
        r = mag % dmag;
        if (r >= dmag - r) q = q + 1;   // nearest, ties away from zero
        if (q[WW-1:XW] != 0) begin
            st = ST_SAT;
            sl = neg ? SLOPE_NEG : SLOPE_POS;
        end else if (neg) begin
            if (q[XW-1:0] > 32'h8000_0000) begin
                st = ST_SAT;
                sl = SLOPE_NEG;
            end else begin
                sl = -q[XW-1:0];
            end
        end else begin
            if (q[XW-1:0] > 32'h7FFF_FFFF) begin
                st = ST_SAT;
                sl = SLOPE_POS;
            end else begin
                sl = q[XW-1:0];
            end
        end
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 3; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        n_held = 0;
    endfunction

    // Slide the window by one sample and queue the results it produces
    function automatic void predict_slopes(input logic [XW-1:0] x, y, input logic last);
        slope_res_t r;
        logic       fin;
        win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = x;
        win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = y;
        n_held++;
        fin = last || (n_held >= MAX_POINTS_DEF);
        if (n_held < 3) begin
            if (fin) begin
                r = '{slope: '0, idx: '0, st: ST_SHORT, fin: 1'b1};
                pending_slopes.push_back(r);
                clear_window();
            end
            return;
        end
        if (n_held == 3) begin
            point_slope(win_x[0], win_y[0], win_x[1], win_y[1], win_x[2], win_y[2],
                        r.slope, r.st);
            r.idx = '0;
            r.fin = 1'b0;
            pending_slopes.push_back(r);
        end
        point_slope(win_x[1], win_y[1], win_x[0], win_y[0], win_x[2], win_y[2],
                    r.slope, r.st);
        r.idx = IDXW'(n_held - 2);
        r.fin = 1'b0;
        pending_slopes.push_back(r);
        if (fin) begin
            point_slope(win_x[2], win_y[2], win_x[1], win_y[1], win_x[0], win_y[0],
                        r.slope, r.st);
            r.idx = IDXW'(n_held - 1);
            r.fin = 1'b1;
            pending_slopes.push_back(r);
            clear_window();
        end
    endfunction

    // Sink side: random stall per result, with bursts of no stall
    initial begin
        int unsigned stall;
        logic        burst;
        burst = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) burst = ~burst;
            stall = burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!(m_valid && m_ready));
            @(posedge aclk);
        end
    end

    // Result checker: every output transfer is matched to the oldest expectation
    always @(negedge aclk) begin
        slope_res_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{slope: m_slope, idx: m_point_index, st: m_status, fin: m_final_result};
            if (pending_slopes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slope=%h idx=%0d st=%0d fin=%0b",
                             got.slope, got.idx, got.st, got.fin);
            end else begin
                want = pending_slopes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp slope=%h idx=%0d st=%0d fin=%0b,",
                                  " got slope=%h idx=%0d st=%0d fin=%0b"},
                                 want.slope, want.idx, want.st, want.fin,
                                 got.slope, got.idx, got.st, got.fin);
                end
            end
        end
    end

    // Hang watchdog: counts cycles in which neither channel transfers
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Source side
    logic src_burst = 1'b0;

    task automatic send_sample(input logic [XW-1:0] x, y, input logic last);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) src_burst = ~src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_x_value     <= x;
        s_y_value     <= y;
        s_last_sample <= last;
        s_valid       <= 1'b1;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_slopes(x, y, last);
    endtask

    sample_row_t directed[] = '{
        // lone sample after reset: short series
        '{32'h0001_0000, 32'h0000_0000, 1'b1, 1'b1, '{'0, '0, ST_SHORT, 1'b1}},
        // two samples: short series
        '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, '0},
        '{32'h0002_0000, 32'h0004_0000, 1'b1, 1'b1, '{'0, '0, ST_SHORT, 1'b1}},
        // exactly three samples: forward, central and backward together
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, '0},
        '{32'h0003_0000, 32'h0009_0000, 1'b1, 1'b0, '0},
        // non-uniform series, longer
        '{32'hFFFF_0000, 32'h0001_8000, 1'b0, 1'b0, '0},
        '{32'h0000_4000, 32'hFFFE_0000, 1'b0, 1'b0, '0},
        '{32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0, '0},
        '{32'h0002_0001, 32'h0003_0005, 1'b0, 1'b0, '0},
        '{32'h0010_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
        // repeated x: zero divisor
        '{32'h0005_0000, 32'h0001_0000, 1'b0, 1'b0, '0},
        '{32'h0005_0000, 32'h0002_0000, 1'b0, 1'b0, '0},
        '{32'h0005_0000, 32'h0002_0000, 1'b1, 1'b0, '0},
        // all-equal samples: zero over zero
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0},
        // field extremes: huge slopes saturate
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h8000_0001, 32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFE, 32'h8000_0000, 1'b1, 1'b0, '0},
        // tiny steps with large y swings
        '{32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 1'b0, '0}
    };

    initial begin
        int unsigned  sent, len, step;
        logic [XW-1:0] x, y;
        int unsigned  kind;
        clear_window();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_sample(directed[i].x, directed[i].y, directed[i].last);
            if (directed[i].typed) begin
                void'(pending_slopes.pop_back());
                pending_slopes.push_back(directed[i].res);
            end
        end

        // Random series: mostly well-formed increasing grids, some noise
        sent = 0;
        while (sent < N_RANDOM) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            x = $urandom;
            for (int k = 0; k < len; k++) begin
                case (kind)
                    1: begin
                        x = $urandom;   // arbitrary grid, any bit pattern
                        y = $urandom;
                    end
                    2: begin
                        // repeated x now and then
                        if ($urandom_range(0, 2) != 0) x = x + $urandom_range(1, 32'h3_0000);
                        y = $urandom;
                    end
                    default: begin
                        step = $urandom_range(0, 3) == 0 ? $urandom_range(1, 255)
                                                         : $urandom_range(1, 32'h4_0000);
                        x = x + step;
                        y = $urandom_range(0, 1) ? $urandom : {{12{1'b0}}, 20'($urandom)};
                    end
                endcase
                send_sample(x, y, k == len - 1);
                sent++;
            end
        end
        s_valid <= 1'b0;

        wait (pending_slopes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_slopes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* nonuniform_grid_gradient_top.f */
design/nug_pkg.sv
design/nonuniform_grid_gradient_top.sv
verif/tb_nonuniform_grid_gradient_top.sv
